/* src/lru_move_to_front_cache_macros.svh */
// Assertion helpers used by the checker of this block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef LRU_MOVE_TO_FRONT_CACHE_MACROS_SVH
`define LRU_MOVE_TO_FRONT_CACHE_MACROS_SVH

// Same-cycle implication.
`define LMTF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LMTF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lmtf_pkg.sv */
`timescale 1ns / 1ps
package lmtf_pkg;

	localparam int ENTRIES   = 10;
	localparam int KEY_BITS  = 16;
	localparam int NAME_BITS = 32;
	localparam int TEAM_BITS = 16;

	localparam int SLOT_W   = $clog2(ENTRIES);
	localparam int OCC_W    = $clog2(ENTRIES + 1);
	localparam int REC_BITS = NAME_BITS + TEAM_BITS;

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [OCC_W-1:0]    occ_t;
	typedef logic [REC_BITS-1:0] rec_t;

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_FILL   = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		STATUS_HIT  = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FILL = 2'd2
	} status_t;

	typedef struct packed {
		req_type_t            req_type;
		logic [KEY_BITS-1:0]  player_id;
		logic [NAME_BITS-1:0] name_tag;
		logic [TEAM_BITS-1:0] team_tag;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [KEY_BITS-1:0]  result_id;
		logic [NAME_BITS-1:0] result_name_tag;
		logic [TEAM_BITS-1:0] result_team_tag;
		logic                 evicted;
	} rsp_t;

endpackage

/* src/lmtf_ram.sv */
`timescale 1ns / 1ps
module lmtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* src/lru_move_to_front_cache.sv */
`timescale 1ns / 1ps
// Fully associative cache of up to ENTRIES records kept in recency order.
// Request channel (req_valid/req_ready, payload req): a lookup by player_id,
// or a fill that writes a record read from the backing store.
// Response channel (rsp_valid/rsp_ready, payload rsp): exactly one response
// per request, in request order: hit with the record, miss, or fill done
// (with evicted set when the least recent record was dropped).
// Steps per request: accept, search (key compare against all slots and
// record RAM read), commit (RAM write, recency update, response register);
// a new request is accepted only after the commit of the previous one.
// Keys and recency ranks sit in per-slot registers; name and team live in a
// one-port-read, one-port-write RAM, read in search and written in commit.
// A response waiting in the output register does not block the next request;
// only the commit of the following one holds until rsp_ready takes it.
// Reset empties the cache (occupancy zero) and drops any pending response;
// no clearing pass is needed, so requests are taken right after reset.
module lru_move_to_front_cache (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lmtf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lmtf_pkg::rsp_t rsp
);
	import lmtf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	state_t state_q;
	occ_t   occ_q;
	req_t   req_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic [KEY_BITS-1:0] key_q  [ENTRIES];
	slot_t               rank_q [ENTRIES];

	// search results, held into commit
	logic  hit_q;
	logic  grow_q;
	logic  evict_q;
	slot_t target_q;
	slot_t lim_q;

	logic [ENTRIES-1:0] match;
	logic  hit;
	logic  full;
	slot_t hit_slot;
	slot_t victim_slot;
	slot_t target;
	slot_t lim;
	logic  commit;
	logic  update;
	logic  is_fill;
	rec_t  rd_rec;

	assign is_fill = (req_q.req_type == REQ_FILL);
	assign full    = (occ_q == occ_t'(ENTRIES));

	always_comb begin
		hit_slot    = '0;
		victim_slot = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (occ_t'(i) < occ_q) && (key_q[i] == req_q.player_id);
			if (match[i]) begin
				hit_slot = hit_slot | slot_t'(i);
			end
			if (rank_q[i] == slot_t'(ENTRIES - 1)) begin
				victim_slot = victim_slot | slot_t'(i);
			end
		end
		hit = |match;
		if (hit) begin
			target = hit_slot;
			lim    = rank_q[hit_slot];
		end else if (full) begin
			target = victim_slot;
			lim    = slot_t'(ENTRIES - 1);
		end else begin
			target = occ_q[SLOT_W-1:0];
			lim    = occ_q[SLOT_W-1:0];
		end
	end

	assign commit = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_ready);
	assign update = commit && (is_fill || hit_q);

	lmtf_ram #(
		.WIDTH(REC_BITS),
		.DEPTH(ENTRIES)
	) u_rec_ram (
		.clk    (clk),
		.wr_en  (commit && is_fill),
		.wr_addr(target_q),
		.wr_data({req_q.name_tag, req_q.team_tag}),
		.rd_en  (state_q == ST_SEARCH),
		.rd_addr(hit_slot),
		.rd_data(rd_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (commit && grow_q) begin
							occ_q <= occ_q + occ_t'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_SEARCH) begin
			hit_q    <= hit;
			target_q <= target;
			lim_q    <= lim;
			grow_q   <= is_fill && !hit && !full;
			evict_q  <= !hit && full;
		end
		if (commit) begin
			rsp_q.result_id <= req_q.player_id;
			if (is_fill) begin
				rsp_q.status          <= STATUS_FILL;
				rsp_q.result_name_tag <= req_q.name_tag;
				rsp_q.result_team_tag <= req_q.team_tag;
				rsp_q.evicted         <= evict_q;
			end else if (hit_q) begin
				rsp_q.status          <= STATUS_HIT;
				rsp_q.result_name_tag <= rd_rec[REC_BITS-1:TEAM_BITS];
				rsp_q.result_team_tag <= rd_rec[TEAM_BITS-1:0];
				rsp_q.evicted         <= 1'b0;
			end else begin
				rsp_q.status          <= STATUS_MISS;
				rsp_q.result_name_tag <= '0;
				rsp_q.result_team_tag <= '0;
				rsp_q.evicted         <= 1'b0;
			end
		end
	end

	// move target to the front; age every valid slot that was ahead of it
	always_ff @(posedge clk) begin
		if (update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_t'(i) == target_q) begin
					rank_q[i] <= '0;
					key_q[i]  <= req_q.player_id;
				end else if ((occ_t'(i) < occ_q) && (rank_q[i] < lim_q)) begin
					rank_q[i] <= rank_q[i] + slot_t'(1);
				end
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* src/lmtf_checker.sv */
`timescale 1ns / 1ps
`include "lru_move_to_front_cache_macros.svh"
module lmtf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input lmtf_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input lmtf_pkg::rsp_t rsp
);
	import lmtf_pkg::*;

	`LMTF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")
	`LMTF_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
	`LMTF_ASSERT_NOW(a_miss_zero, rsp_valid && rsp.status == STATUS_MISS, rsp.result_name_tag == '0 && rsp.result_team_tag == '0, "miss carries record data")
	`LMTF_ASSERT_NOW(a_evict_fill, rsp_valid && rsp.evicted, rsp.status == STATUS_FILL, "eviction flagged outside a fill")

endmodule

bind lru_move_to_front_cache lmtf_checker u_lmtf_checker (.*);
